/* rtl/core/hatd_pkg.sv */
// shared types, constants and helper functions for the hinge angle pipeline
package hatd_pkg;

    // field widths
    localparam int COORD_W = 32;
    localparam int LEN_W   = 31;
    localparam int TURN_W  = 20;

    // internal angle format: q30 radians
    localparam int ANG_Q        = 30;
    localparam int CORDIC_STEPS = 30;
    localparam int DIV_STEPS    = 30;
    localparam int CW           = 34;  // cordic x, y and z datapath
    localparam int BW           = 34;  // signed base angle
    localparam int DW           = 35;  // signed turn angle before rounding

    localparam logic [31:0] ANG_PI      = 32'd3373259426;
    localparam logic [31:0] ANG_HALF_PI = 32'd1686629713;

    // saturation limits of the turn angle in the wide format
    localparam logic signed [DW-1:0] TURN_MAX = {{(DW-TURN_W+1){1'b0}}, {(TURN_W-1){1'b1}}};
    localparam logic signed [DW-1:0] TURN_MIN = {{(DW-TURN_W+1){1'b1}}, {(TURN_W-1){1'b0}}};

    // hinge axis codes
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // outcome codes
    typedef enum logic [1:0] {
        OUT_EXACT = 2'd0,
        OUT_FAR   = 2'd1,
        OUT_NEAR  = 2'd2
    } t_outcome;

    // input item
    typedef struct packed {
        logic signed [COORD_W-1:0] grab_x;
        logic signed [COORD_W-1:0] grab_y;
        logic signed [COORD_W-1:0] grab_z;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
        logic        [LEN_W-1:0]   rope_length;
        logic signed [COORD_W-1:0] hinge_x;
        logic signed [COORD_W-1:0] hinge_y;
        logic signed [COORD_W-1:0] hinge_z;
    } t_in;

    // result item
    typedef struct packed {
        logic signed [TURN_W-1:0] turn_angle;
        logic        [1:0]        outcome;
    } t_out;

    // carried beside the base angle unit
    typedef struct packed {
        logic [63:0] r2;
        logic [63:0] d2;
        logic [63:0] f2;
        logic        cross_neg;
        logic        rd_zero;
    } t_base_side;

    // carried beside the three roots
    typedef struct packed {
        logic signed [BW-1:0] delta;
        logic [63:0]          r2;
        logic [63:0]          d2;
        logic [63:0]          f2;
    } t_root_side;

    // carried through the law of cosines path
    typedef struct packed {
        logic signed [BW-1:0] delta;
        logic [1:0]           outcome;
        logic                 den_zero;
    } t_law_side;

    // carried beside the sine root
    typedef struct packed {
        t_law_side   law;
        logic        neg;
        logic [30:0] q;
    } t_arg_side;

    // difference clamped to +-(2^31 - 1)
    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        if (d > 33'sd2147483647) begin
            return 32'sd2147483647;
        end else if (d < -33'sd2147483647) begin
            return -32'sd2147483647;
        end
        return d[31:0];
    endfunction

    // arctangent of 2^-i in q30
    function automatic logic [31:0] atan_q30(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            default: v = 32'd1 << (30 - i);
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/hatd_isqrt.sv */
// pipelined floor square root, one result bit per stage, with a sideband
module hatd_isqrt #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SIDE_W-1:0]   i_side,
    input  logic [IN_W-1:0]     i_value,
    output logic                o_valid,
    output logic [SIDE_W-1:0]   o_side,
    output logic [IN_W/2-1:0]   o_root
);

    localparam int OUT_W = IN_W / 2;

    logic [IN_W-1:0]   r_res   [0:OUT_W-1];
    logic [OUT_W-1:0]  r_root  [0:OUT_W-1];
    logic              r_valid [0:OUT_W-1];
    logic [SIDE_W-1:0] r_side  [0:OUT_W-1];

    genvar g;
    generate
        for (g = 0; g < OUT_W; g++) begin : g_step
            localparam int K = OUT_W - 1 - g;

            logic [IN_W-1:0]   w_res;
            logic [OUT_W-1:0]  w_root;
            logic              w_valid;
            logic [SIDE_W-1:0] w_side;
            logic [IN_W:0]     w_cand;
            logic              w_take;

            if (g == 0) begin : g_first
                assign w_res   = i_value;
                assign w_root  = '0;
                assign w_valid = i_valid;
                assign w_side  = i_side;
            end else begin : g_next
                assign w_res   = r_res[g-1];
                assign w_root  = r_root[g-1];
                assign w_valid = r_valid[g-1];
                assign w_side  = r_side[g-1];
            end

            // trial (root + 2^k)^2 - root^2
            assign w_cand = ({{(IN_W+1-OUT_W){1'b0}}, w_root} << (K + 1))
                          + ({{IN_W{1'b0}}, 1'b1} << (2 * K));
            assign w_take = w_cand <= {1'b0, w_res};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[g] <= 1'b0;
                end else if (i_en) begin
                    r_valid[g] <= w_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_res[g]  <= w_take ? (w_res - w_cand[IN_W-1:0]) : w_res;
                    r_root[g] <= w_take ? (w_root | ({{(OUT_W-1){1'b0}}, 1'b1} << K)) : w_root;
                    r_side[g] <= w_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[OUT_W-1];
    assign o_side  = r_side[OUT_W-1];
    assign o_root  = r_root[OUT_W-1];

endmodule

/* rtl/core/hatd_atan2.sv */
// pipelined atan2 for a nonnegative y: normalize shifter, vectoring cordic, clamp
module hatd_atan2 #(
    parameter int MAG_W  = 64,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SIDE_W-1:0] i_side,
    input  logic              i_neg_x,
    input  logic [MAG_W-1:0]  i_mag_x,
    input  logic [MAG_W-1:0]  i_mag_y,
    output logic              o_valid,
    output logic [SIDE_W-1:0] o_side,
    output logic [31:0]       o_angle
);

    localparam int NORM_STEPS = $clog2(MAG_W);
    localparam int STEPS      = hatd_pkg::CORDIC_STEPS;
    localparam int CW         = hatd_pkg::CW;
    localparam int TOP        = hatd_pkg::ANG_Q;

    // normalize stages
    logic [MAG_W-1:0]  r_nx    [0:NORM_STEPS-1];
    logic [MAG_W-1:0]  r_ny    [0:NORM_STEPS-1];
    logic              r_nneg  [0:NORM_STEPS-1];
    logic              r_nval  [0:NORM_STEPS-1];
    logic [SIDE_W-1:0] r_nside [0:NORM_STEPS-1];

    // cordic stages
    logic signed [CW-1:0] r_cx    [0:STEPS-1];
    logic signed [CW-1:0] r_cy    [0:STEPS-1];
    logic signed [CW-1:0] r_z     [0:STEPS-1];
    logic                 r_zero  [0:STEPS-1];
    logic                 r_cval  [0:STEPS-1];
    logic [SIDE_W-1:0]    r_cside [0:STEPS-1];

    // output stage
    logic              r_valid;
    logic [SIDE_W-1:0] r_side;
    logic [31:0]       r_angle;

    logic [TOP-1:0] top_x;
    logic [TOP-1:0] top_y;
    logic           top_zero;

    genvar g;
    generate
        // shift left until the larger magnitude has its top bit set
        for (g = 0; g < NORM_STEPS; g++) begin : g_norm
            localparam int SHIFT = 1 << (NORM_STEPS - 1 - g);

            logic [MAG_W-1:0]  w_x;
            logic [MAG_W-1:0]  w_y;
            logic              w_neg;
            logic              w_valid;
            logic [SIDE_W-1:0] w_side;
            logic              w_fit;

            if (g == 0) begin : g_first
                assign w_x     = i_mag_x;
                assign w_y     = i_mag_y;
                assign w_neg   = i_neg_x;
                assign w_valid = i_valid;
                assign w_side  = i_side;
            end else begin : g_next
                assign w_x     = r_nx[g-1];
                assign w_y     = r_ny[g-1];
                assign w_neg   = r_nneg[g-1];
                assign w_valid = r_nval[g-1];
                assign w_side  = r_nside[g-1];
            end

            assign w_fit = ((w_x | w_y) >> (MAG_W - SHIFT)) == '0;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_nval[g] <= 1'b0;
                end else if (i_en) begin
                    r_nval[g] <= w_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nx[g]    <= w_fit ? (w_x << SHIFT) : w_x;
                    r_ny[g]    <= w_fit ? (w_y << SHIFT) : w_y;
                    r_nneg[g]  <= w_neg;
                    r_nside[g] <= w_side;
                end
            end
        end
    endgenerate

    // keep the top bits so the larger magnitude lies in [2^29, 2^30)
    assign top_x    = r_nx[NORM_STEPS-1][MAG_W-1 -: TOP];
    assign top_y    = r_ny[NORM_STEPS-1][MAG_W-1 -: TOP];
    assign top_zero = !(r_nx[NORM_STEPS-1][MAG_W-1] | r_ny[NORM_STEPS-1][MAG_W-1]);

    generate
        for (g = 0; g < STEPS; g++) begin : g_rot
            logic signed [CW-1:0] w_cx;
            logic signed [CW-1:0] w_cy;
            logic signed [CW-1:0] w_z;
            logic                 w_zero;
            logic                 w_valid;
            logic [SIDE_W-1:0]    w_side;
            logic signed [CW-1:0] w_at;

            if (g == 0) begin : g_first
                // negative x: swap and start from a quarter turn
                assign w_cx    = r_nneg[NORM_STEPS-1] ? $signed({{(CW-TOP){1'b0}}, top_y})
                                                      : $signed({{(CW-TOP){1'b0}}, top_x});
                assign w_cy    = r_nneg[NORM_STEPS-1] ? $signed({{(CW-TOP){1'b0}}, top_x})
                                                      : $signed({{(CW-TOP){1'b0}}, top_y});
                assign w_z     = r_nneg[NORM_STEPS-1]
                               ? $signed({{(CW-32){1'b0}}, hatd_pkg::ANG_HALF_PI}) : '0;
                assign w_zero  = top_zero;
                assign w_valid = r_nval[NORM_STEPS-1];
                assign w_side  = r_nside[NORM_STEPS-1];
            end else begin : g_next
                assign w_cx    = r_cx[g-1];
                assign w_cy    = r_cy[g-1];
                assign w_z     = r_z[g-1];
                assign w_zero  = r_zero[g-1];
                assign w_valid = r_cval[g-1];
                assign w_side  = r_cside[g-1];
            end

            assign w_at = $signed({{(CW-32){1'b0}}, hatd_pkg::atan_q30(g)});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cval[g] <= 1'b0;
                end else if (i_en) begin
                    r_cval[g] <= w_valid;
                end
            end

            // rotate toward the x axis
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!w_cy[CW-1]) begin
                        r_cx[g] <= w_cx + (w_cy >>> g);
                        r_cy[g] <= w_cy - (w_cx >>> g);
                        r_z[g]  <= w_z + w_at;
                    end else begin
                        r_cx[g] <= w_cx - (w_cy >>> g);
                        r_cy[g] <= w_cy + (w_cx >>> g);
                        r_z[g]  <= w_z - w_at;
                    end
                    r_zero[g]  <= w_zero;
                    r_cside[g] <= w_side;
                end
            end
        end
    endgenerate

    // clamp to [0, pi]; zero vector reads as a quarter turn
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_cval[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= r_cside[STEPS-1];
            if (r_zero[STEPS-1]) begin
                r_angle <= hatd_pkg::ANG_HALF_PI;
            end else if (r_z[STEPS-1][CW-1]) begin
                r_angle <= '0;
            end else if (r_z[STEPS-1] > $signed({{(CW-32){1'b0}}, hatd_pkg::ANG_PI})) begin
                r_angle <= hatd_pkg::ANG_PI;
            end else begin
                r_angle <= r_z[STEPS-1][31:0];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_angle = r_angle;

endmodule

/* rtl/core/hinge_angle_for_target_distance.sv */
// top level: hinge turn angle toward a target at a given rope length
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  input    | i_valid / o_stall      | i_item  (hatd_pkg::t_in)
//  output   | o_valid / i_stall      | o_item  (hatd_pkg::t_out)
//  config   | i_cfg_we               | i_cfg_wdata (hinge axis)
//
//  one item per cycle while the result is not stalled; the depth from accept to result is
//  set by the chain of cordic, root and divide stages, each one bit or one step a stage.
//  i_rst_n is synchronous and clears the valid bits, the skid slot and the axis register.
//  a stalled result freezes the whole pipeline; one more item is still taken into a
//  skid slot, and o_stall rises only while that slot is full.
module hinge_angle_for_target_distance #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  hatd_pkg::t_in     i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output hatd_pkg::t_out    o_item
);

    localparam int SH    = hatd_pkg::ANG_Q - ANGLE_FRAC_BITS;
    localparam int BW    = hatd_pkg::BW;
    localparam int DW    = hatd_pkg::DW;
    localparam int DSTEP = hatd_pkg::DIV_STEPS;

    logic en;

    // configuration
    logic [1:0] r_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= hatd_pkg::AXIS_X;
        end else if (i_cfg_we) begin
            r_axis <= i_cfg_wdata;
        end
    end

    // skid slot and pipeline enable
    logic          r_skid_valid;
    hatd_pkg::t_in r_skid;
    hatd_pkg::t_in front;
    logic          front_valid;
    logic          r_k_valid;
    hatd_pkg::t_out r_k_item;

    assign en          = !r_k_valid || !i_stall;
    assign o_stall     = r_skid_valid;
    assign front       = r_skid_valid ? r_skid : i_item;
    assign front_valid = r_skid_valid | i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (en) begin
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && i_valid && !r_skid_valid) begin
            r_skid <= i_item;
        end
    end

    // stage a: axis selection and clamped differences
    logic signed [31:0] s_gu, s_gv, s_tu, s_tv, s_hu, s_hv, s_ga, s_ta;

    always_comb begin
        case (r_axis)
            hatd_pkg::AXIS_Y: begin
                s_ga = front.grab_y;   s_ta = front.target_y;
                s_gu = front.grab_z;   s_tu = front.target_z;   s_hu = front.hinge_z;
                s_gv = front.grab_x;   s_tv = front.target_x;   s_hv = front.hinge_x;
            end
            hatd_pkg::AXIS_Z: begin
                s_ga = front.grab_z;   s_ta = front.target_z;
                s_gu = front.grab_x;   s_tu = front.target_x;   s_hu = front.hinge_x;
                s_gv = front.grab_y;   s_tv = front.target_y;   s_hv = front.hinge_y;
            end
            default: begin
                s_ga = front.grab_x;   s_ta = front.target_x;
                s_gu = front.grab_y;   s_tu = front.target_y;   s_hu = front.hinge_y;
                s_gv = front.grab_z;   s_tv = front.target_z;   s_hv = front.hinge_z;
            end
        endcase
    end

    logic               r_a_valid;
    logic signed [31:0] r_a_ru, r_a_rv, r_a_tu, r_a_tv, r_a_h;
    logic [30:0]        r_a_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= front_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ru  <= hatd_pkg::sat_diff(s_gu, s_hu);
            r_a_rv  <= hatd_pkg::sat_diff(s_gv, s_hv);
            r_a_tu  <= hatd_pkg::sat_diff(s_tu, s_hu);
            r_a_tv  <= hatd_pkg::sat_diff(s_tv, s_hv);
            r_a_h   <= hatd_pkg::sat_diff(s_ta, s_ga);
            r_a_len <= front.rope_length;
        end
    end

    // stage b: products
    logic               r_b_valid;
    logic signed [63:0] r_b_ru2, r_b_rv2, r_b_tu2, r_b_tv2, r_b_h2;
    logic signed [63:0] r_b_c1, r_b_c2, r_b_d1, r_b_d2;
    logic [61:0]        r_b_len2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ru2  <= r_a_ru * r_a_ru;
            r_b_rv2  <= r_a_rv * r_a_rv;
            r_b_tu2  <= r_a_tu * r_a_tu;
            r_b_tv2  <= r_a_tv * r_a_tv;
            r_b_h2   <= r_a_h * r_a_h;
            r_b_c1   <= r_a_ru * r_a_tv;
            r_b_c2   <= r_a_rv * r_a_tu;
            r_b_d1   <= r_a_ru * r_a_tu;
            r_b_d2   <= r_a_rv * r_a_tv;
            r_b_len2 <= r_a_len * r_a_len;
        end
    end

    // stage c: squared lengths, cross and dot
    logic               r_c_valid;
    logic [63:0]        r_c_r2, r_c_d2, r_c_f2;
    logic signed [63:0] r_c_cross, r_c_dot;
    logic [63:0]        len2_ext;

    assign len2_ext = {2'b00, r_b_len2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_r2    <= $unsigned(r_b_ru2) + $unsigned(r_b_rv2);
            r_c_d2    <= $unsigned(r_b_tu2) + $unsigned(r_b_tv2);
            r_c_f2    <= (len2_ext > $unsigned(r_b_h2)) ? (len2_ext - $unsigned(r_b_h2)) : '0;
            r_c_cross <= r_b_c1 - r_b_c2;
            r_c_dot   <= r_b_d1 + r_b_d2;
        end
    end

    // base angle between grab and target directions
    hatd_pkg::t_base_side base_in;
    hatd_pkg::t_base_side base_out;
    logic                 base_valid;
    logic [31:0]          base_angle;

    assign base_in.r2        = r_c_r2;
    assign base_in.d2        = r_c_d2;
    assign base_in.f2        = r_c_f2;
    assign base_in.cross_neg = r_c_cross[63];
    assign base_in.rd_zero   = (r_c_r2 == '0) || (r_c_d2 == '0);

    hatd_atan2 #(
        .MAG_W  (64),
        .SIDE_W ($bits(hatd_pkg::t_base_side))
    ) u_base_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_c_valid),
        .i_side  (base_in),
        .i_neg_x (r_c_dot[63]),
        .i_mag_x (r_c_dot[63] ? $unsigned(-r_c_dot) : $unsigned(r_c_dot)),
        .i_mag_y (r_c_cross[63] ? $unsigned(-r_c_cross) : $unsigned(r_c_cross)),
        .o_valid (base_valid),
        .o_side  (base_out),
        .o_angle (base_angle)
    );

    // signed base angle, then the three roots
    hatd_pkg::t_root_side root_in;
    hatd_pkg::t_root_side root_out;
    logic                 root_valid;
    logic [31:0]          rr, dd, ff;
    logic signed [BW-1:0] base_ext;

    assign base_ext      = $signed({{(BW-32){1'b0}}, base_angle});
    assign root_in.delta = base_out.rd_zero
                         ? $signed({{(BW-32){1'b0}}, hatd_pkg::ANG_HALF_PI})
                         : (base_out.cross_neg ? -base_ext : base_ext);
    assign root_in.r2    = base_out.r2;
    assign root_in.d2    = base_out.d2;
    assign root_in.f2    = base_out.f2;

    hatd_isqrt #(
        .IN_W   (64),
        .SIDE_W ($bits(hatd_pkg::t_root_side))
    ) u_root_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (base_valid),
        .i_side  (root_in),
        .i_value (base_out.r2),
        .o_valid (root_valid),
        .o_side  (root_out),
        .o_root  (rr)
    );

    hatd_isqrt #(
        .IN_W   (64),
        .SIDE_W (1)
    ) u_root_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (base_valid),
        .i_side  (1'b0),
        .i_value (base_out.d2),
        .o_valid (),
        .o_side  (),
        .o_root  (dd)
    );

    hatd_isqrt #(
        .IN_W   (64),
        .SIDE_W (1)
    ) u_root_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (base_valid),
        .i_side  (1'b0),
        .i_value (base_out.f2),
        .o_valid (),
        .o_side  (),
        .o_root  (ff)
    );

    // stage e: reach tests, r*d and r2+d2
    logic                 r_e_valid;
    logic signed [BW-1:0] r_e_delta;
    logic [1:0]           r_e_outcome;
    logic [63:0]          r_e_rd, r_e_sum, r_e_f2;
    logic [32:0]          sum_dr, sum_fr;
    logic                 too_far, too_near;

    assign sum_dr   = {1'b0, dd} + {1'b0, rr};
    assign sum_fr   = {1'b0, ff} + {1'b0, rr};
    assign too_far  = {1'b0, ff} > sum_dr;
    assign too_near = sum_fr < {1'b0, dd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= root_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_delta   <= root_out.delta;
            r_e_outcome <= too_far ? hatd_pkg::OUT_FAR
                         : (too_near ? hatd_pkg::OUT_NEAR : hatd_pkg::OUT_EXACT);
            r_e_rd      <= rr * dd;
            r_e_sum     <= root_out.r2 + root_out.d2;
            r_e_f2      <= root_out.f2;
        end
    end

    // stage f: divisor and numerator magnitude
    logic                r_f_valid;
    logic [63:0]         r_f_den, r_f_nm;
    logic                r_f_neg;
    hatd_pkg::t_law_side r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_den           <= {r_e_rd[62:0], 1'b0};
            r_f_nm            <= (r_e_sum >= r_e_f2) ? (r_e_sum - r_e_f2) : (r_e_f2 - r_e_sum);
            r_f_neg           <= r_e_sum < r_e_f2;
            r_f_side.delta    <= r_e_delta;
            r_f_side.outcome  <= r_e_outcome;
            r_f_side.den_zero <= r_e_rd == '0;
        end
    end

    // restoring divider, one quotient bit a stage
    logic [63:0]         r_dv_rem   [0:DSTEP-1];
    logic [DSTEP-1:0]    r_dv_q     [0:DSTEP-1];
    logic [63:0]         r_dv_den   [0:DSTEP-1];
    logic                r_dv_full  [0:DSTEP-1];
    logic                r_dv_neg   [0:DSTEP-1];
    logic                r_dv_valid [0:DSTEP-1];
    hatd_pkg::t_law_side r_dv_side  [0:DSTEP-1];

    genvar g;
    generate
        for (g = 0; g < DSTEP; g++) begin : g_div
            logic [63:0]         w_rem;
            logic [DSTEP-1:0]    w_q;
            logic [63:0]         w_den;
            logic                w_full;
            logic                w_neg;
            logic                w_valid;
            hatd_pkg::t_law_side w_side;
            logic [64:0]         w_trial;
            logic                w_ge;

            if (g == 0) begin : g_first
                assign w_rem   = r_f_nm;
                assign w_q     = '0;
                assign w_den   = r_f_den;
                assign w_full  = r_f_nm >= r_f_den;
                assign w_neg   = r_f_neg;
                assign w_valid = r_f_valid;
                assign w_side  = r_f_side;
            end else begin : g_next
                assign w_rem   = r_dv_rem[g-1];
                assign w_q     = r_dv_q[g-1];
                assign w_den   = r_dv_den[g-1];
                assign w_full  = r_dv_full[g-1];
                assign w_neg   = r_dv_neg[g-1];
                assign w_valid = r_dv_valid[g-1];
                assign w_side  = r_dv_side[g-1];
            end

            assign w_trial = {w_rem, 1'b0};
            assign w_ge    = w_trial >= {1'b0, w_den};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv_valid[g] <= 1'b0;
                end else if (en) begin
                    r_dv_valid[g] <= w_valid;
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_rem[g]  <= w_ge ? (w_trial[63:0] - w_den) : w_trial[63:0];
                    r_dv_q[g]    <= {w_q[DSTEP-2:0], w_ge};
                    r_dv_den[g]  <= w_den;
                    r_dv_full[g] <= w_full;
                    r_dv_neg[g]  <= w_neg;
                    r_dv_side[g] <= w_side;
                end
            end
        end
    endgenerate

    // stage h: cosine magnitude and its square
    logic                r_h_valid;
    logic [30:0]         r_h_q;
    logic [61:0]         r_h_sq;
    logic                r_h_neg;
    hatd_pkg::t_law_side r_h_side;
    logic [30:0]         cos_q;

    assign cos_q = r_dv_full[DSTEP-1] ? {1'b1, {DSTEP{1'b0}}} : {1'b0, r_dv_q[DSTEP-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (en) begin
            r_h_valid <= r_dv_valid[DSTEP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_q    <= cos_q;
            r_h_sq   <= cos_q * cos_q;
            r_h_neg  <= r_dv_neg[DSTEP-1];
            r_h_side <= r_dv_side[DSTEP-1];
        end
    end

    // stage i: 1 - c^2 in q60
    logic                r_i_valid;
    logic [61:0]         r_i_arg;
    hatd_pkg::t_arg_side r_i_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (en) begin
            r_i_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_arg       <= ({{61{1'b0}}, 1'b1} << 60) - r_h_sq;
            r_i_side.law  <= r_h_side;
            r_i_side.neg  <= r_h_neg;
            r_i_side.q    <= r_h_q;
        end
    end

    // sine root, then acos as atan2(sine, cosine)
    hatd_pkg::t_arg_side sin_side;
    logic                sin_valid;
    logic [30:0]         sin_root;
    hatd_pkg::t_law_side law_out;
    logic                law_valid;
    logic [31:0]         law_angle;

    hatd_isqrt #(
        .IN_W   (62),
        .SIDE_W ($bits(hatd_pkg::t_arg_side))
    ) u_root_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_i_valid),
        .i_side  (r_i_side),
        .i_value (r_i_arg),
        .o_valid (sin_valid),
        .o_side  (sin_side),
        .o_root  (sin_root)
    );

    hatd_atan2 #(
        .MAG_W  (32),
        .SIDE_W ($bits(hatd_pkg::t_law_side))
    ) u_law_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sin_valid),
        .i_side  (sin_side.law),
        .i_neg_x (sin_side.neg && (sin_side.q != '0)),
        .i_mag_x ({1'b0, sin_side.q}),
        .i_mag_y ({1'b0, sin_root}),
        .o_valid (law_valid),
        .o_side  (law_out),
        .o_angle (law_angle)
    );

    // stage j: apply the outcome
    logic                 r_j_valid;
    logic signed [DW-1:0] r_j_delta;
    logic [1:0]           r_j_outcome;
    logic signed [DW-1:0] delta_ext;
    logic signed [DW-1:0] added;
    logic signed [DW-1:0] n_delta;

    assign delta_ext = $signed({{(DW-BW){law_out.delta[BW-1]}}, law_out.delta});
    assign added     = law_out.den_zero ? '0 : $signed({{(DW-32){1'b0}}, law_angle});

    always_comb begin
        case (law_out.outcome)
            hatd_pkg::OUT_FAR:  n_delta = delta_ext + $signed({{(DW-32){1'b0}}, hatd_pkg::ANG_PI});
            hatd_pkg::OUT_NEAR: n_delta = delta_ext;
            default:            n_delta = (delta_ext > 0) ? (delta_ext - added) : (delta_ext + added);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_valid <= 1'b0;
        end else if (en) begin
            r_j_valid <= law_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j_delta   <= n_delta;
            r_j_outcome <= law_out.outcome;
        end
    end

    // stage k: round half up, saturate, output register
    logic signed [DW-1:0] rounded;

    assign rounded = (r_j_delta + $signed({{(DW-1){1'b0}}, 1'b1} << (SH - 1))) >>> SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_valid <= 1'b0;
        end else if (en) begin
            r_k_valid <= r_j_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_k_item.outcome <= r_j_outcome;
            if (rounded > hatd_pkg::TURN_MAX) begin
                r_k_item.turn_angle <= hatd_pkg::TURN_MAX[hatd_pkg::TURN_W-1:0];
            end else if (rounded < hatd_pkg::TURN_MIN) begin
                r_k_item.turn_angle <= hatd_pkg::TURN_MIN[hatd_pkg::TURN_W-1:0];
            end else begin
                r_k_item.turn_angle <= rounded[hatd_pkg::TURN_W-1:0];
            end
        end
    end

    assign o_valid = r_k_valid;
    assign o_item  = r_k_item;

endmodule
